// ----- src/spsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsc_pkg
// Shared types and constants for the servo pulse slew controller.
// ----------------------------------------------------------------------------
package spsc_pkg;

    localparam int MaxChannels = 16;
    localparam int ChBits      = 4;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_MOVE = 2'd1;
    localparam logic [1:0] OP_CAL  = 2'd2;
    localparam logic [1:0] OP_RSVD = 2'd3;

    localparam logic       REG_ACTIVE = 1'b0;
    localparam logic       REG_CENTER = 1'b1;

    localparam logic [7:0]  MID_ANGLE    = 8'd90;
    localparam logic [9:0]  CAL_SPEED    = 10'd10;
    localparam logic [15:0] CENTER_RESET = 16'd1500;
    localparam logic [4:0]  ACTIVE_RESET = 5'd1;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  channel;
        logic [7:0]  angle;
        logic [9:0]  speed;
        logic [15:0] pulse_min;
        logic [15:0] pulse_max;
        logic [8:0]  span_degrees;
        logic [7:0]  trim_degrees;
    } t_cmd;

    typedef struct packed {
        logic        kind;
        logic [3:0]  channel_res;
        logic [15:0] pulse;
        logic        driven;
        logic        accepted;
        logic        last;
    } t_res;

endpackage

// ----- src/spsc_cmd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsc_cmd_if
// Command channel: valid, ready and one command beat.
// ----------------------------------------------------------------------------
interface spsc_cmd_if;
    logic           valid;
    logic           ready;
    spsc_pkg::t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/spsc_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsc_res_if
// Result channel: valid, ready and one result beat.
// ----------------------------------------------------------------------------
interface spsc_res_if;
    logic           valid;
    logic           ready;
    spsc_pkg::t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/servo_pulse_slew_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_pulse_slew_controller
// Per-channel servo pulse targets with a slew-rate limit per tick.
// ----------------------------------------------------------------------------
// One command is taken at a time, and a new one only once the previous result
// beat has been taken. A move reads the channel table, multiplies by the
// pulses-per-degree factor, then scales and clamps. A calibrate waits on the
// 24-step bit-serial divider that forms the factor. A tick walks the active
// channels one at a time, waiting for each result beat to be taken. Channel
// state lives in registers that reset clears.
module servo_pulse_slew_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    spsc_cmd_if.sink    i_cmd,
    spsc_res_if.source  o_res
);
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_MUL, S_MOVE, S_DIV, S_TICK, S_OUT
    } t_state;

    t_state r_state;
    logic [4:0]  r_active;
    logic [15:0] r_center;
    logic [15:0] r_pos  [spsc_pkg::MaxChannels];
    logic [15:0] r_tgt  [spsc_pkg::MaxChannels];
    logic [9:0]  r_spd  [spsc_pkg::MaxChannels];
    logic [15:0] r_lo   [spsc_pkg::MaxChannels];
    logic [15:0] r_hi   [spsc_pkg::MaxChannels];
    logic [15:0] r_ppd  [spsc_pkg::MaxChannels];
    logic [7:0]  r_trim [spsc_pkg::MaxChannels];

    spsc_pkg::t_cmd r_cmd;
    spsc_pkg::t_res r_res;
    logic        r_vld;
    logic [3:0]  r_ch;
    logic signed [9:0]  r_deg;
    logic signed [26:0] r_prod;
    logic        r_div_go;
    logic [4:0]  w_live;
    logic        w_ok_ch;
    logic [23:0] w_quot;
    logic        w_div_done;
    logic signed [27:0] w_sum;
    logic [27:0] w_mag;
    logic [19:0] w_m;
    logic [15:0] w_ms, w_tc;
    logic signed [17:0] w_p, w_t, w_np, w_d, w_ad, w_ntp;
    logic [15:0] w_npos, w_ntgt, w_pc;

    assign w_live  = (r_active > 5'd16) ? 5'd16 : r_active;
    assign w_ok_ch = {1'b0, r_cmd.channel} < w_live;
    assign i_cmd.ready = (r_state == S_IDLE) && !r_vld;
    assign o_res.valid = r_vld;
    assign o_res.data  = r_res;

    spsc_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_num(r_cmd.pulse_max - r_cmd.pulse_min), .i_den(r_cmd.span_degrees),
        .o_done(w_div_done), .o_quot(w_quot)
    );

    // Move arithmetic: center*256 + product, magnitude, scale, clamp.
    assign w_sum = $signed({4'd0, r_center, 8'd0}) + 28'(r_prod);
    assign w_mag = w_sum[27] ? 28'(-w_sum) : 28'(w_sum);
    assign w_m   = w_mag[27:8];
    assign w_ms  = (w_m > 20'hFFFF) ? 16'hFFFF : w_m[15:0];
    assign w_tc  = (w_ms < r_lo[r_ch]) ? r_lo[r_ch]
                 : (w_ms > r_hi[r_ch]) ? r_hi[r_ch] : w_ms;

    // Tick step for the current channel.
    always_comb begin
        w_p   = $signed({2'd0, r_pos[r_ch]});
        w_t   = $signed({2'd0, r_tgt[r_ch]});
        w_ntp = w_t;
        if (w_p > w_t)      w_np = w_p - $signed({8'd0, r_spd[r_ch]});
        else if (w_p < w_t) w_np = w_p + $signed({8'd0, r_spd[r_ch]});
        else begin
            w_np  = w_p;
            w_ntp = '0;
        end
        w_d  = w_np - w_ntp;
        w_ad = w_d[17] ? -w_d : w_d;
        if (w_ad < $signed({8'd0, r_spd[r_ch]})) w_np = w_ntp;
        w_npos = w_np[15:0];
        w_ntgt = w_ntp[15:0];
        w_pc   = (w_npos < r_lo[r_ch]) ? r_lo[r_ch]
               : (w_npos > r_hi[r_ch]) ? r_hi[r_ch] : w_npos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vld    <= 1'b0;
            r_div_go <= 1'b0;
            r_active <= spsc_pkg::ACTIVE_RESET;
            r_center <= spsc_pkg::CENTER_RESET;
            for (int i = 0; i < spsc_pkg::MaxChannels; i++) begin
                r_pos[i] <= '0; r_tgt[i] <= '0; r_spd[i] <= '0;
                r_lo[i] <= '0; r_hi[i] <= '0; r_ppd[i] <= '0; r_trim[i] <= '0;
            end
        end else begin
            if (r_div_go) r_div_go <= 1'b0;
            if (r_vld && o_res.ready) r_vld <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == spsc_pkg::REG_ACTIVE) r_active <= i_cfg_data[4:0];
                else r_center <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid && !r_vld) begin
                        r_cmd   <= i_cmd.data;
                        r_ch    <= i_cmd.data.channel;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_res <= '{kind: 1'b0, channel_res: r_cmd.channel, pulse: 16'd0,
                               driven: 1'b0, accepted: 1'b0, last: 1'b1};
                    r_deg <= $signed({2'd0, r_cmd.angle}) - $signed({2'd0, spsc_pkg::MID_ANGLE})
                           + $signed({2'd0, r_trim[r_ch]});
                    case (r_cmd.op)
                        spsc_pkg::OP_TICK: begin
                            r_ch <= '0;
                            if (w_live == 5'd0) r_state <= S_IDLE;
                            else r_state <= S_TICK;
                        end
                        spsc_pkg::OP_MOVE: begin
                            if (w_ok_ch && r_cmd.angle <= 8'd180) r_state <= S_MUL;
                            else r_state <= S_OUT;
                        end
                        spsc_pkg::OP_CAL: begin
                            if (w_ok_ch && r_cmd.span_degrees != 9'd0
                                && r_cmd.pulse_min <= r_cmd.pulse_max) begin
                                r_div_go <= 1'b1;
                                r_state  <= S_DIV;
                            end else r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_MUL: begin
                    r_prod  <= 27'(r_deg * $signed({1'b0, r_ppd[r_ch]}));
                    r_state <= S_MOVE;
                end
                S_MOVE: begin
                    r_tgt[r_ch] <= w_tc;
                    r_spd[r_ch] <= r_cmd.speed;
                    r_res.accepted <= 1'b1;
                    r_state <= S_OUT;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_ppd[r_ch]  <= (w_quot > 24'hFFFF) ? 16'hFFFF : w_quot[15:0];
                        r_lo[r_ch]   <= r_cmd.pulse_min;
                        r_hi[r_ch]   <= r_cmd.pulse_max;
                        r_trim[r_ch] <= r_cmd.trim_degrees;
                        r_spd[r_ch]  <= spsc_pkg::CAL_SPEED;
                        r_pos[r_ch]  <= r_center;
                        r_tgt[r_ch]  <= r_center;
                        r_res.accepted <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_TICK: begin
                    // One channel per pass; wait until the previous beat has gone.
                    if (!r_vld) begin
                        r_res.kind <= 1'b1;
                        r_res.channel_res <= r_ch;
                        r_res.accepted <= 1'b0;
                        r_res.last <= ({1'b0, r_ch} + 5'd1 == w_live);
                        if (r_pos[r_ch] == 16'd0 || r_tgt[r_ch] == 16'd0) begin
                            r_res.pulse  <= 16'd0;
                            r_res.driven <= 1'b0;
                        end else begin
                            r_pos[r_ch]  <= w_npos;
                            r_tgt[r_ch]  <= w_ntgt;
                            r_res.pulse  <= w_pc;
                            r_res.driven <= 1'b1;
                        end
                        r_vld <= 1'b1;
                        if ({1'b0, r_ch} + 5'd1 == w_live) r_state <= S_OUT;
                        else r_ch <= r_ch + 4'd1;
                    end
                end
                S_OUT: begin
                    if (r_cmd.op != spsc_pkg::OP_TICK) r_vld <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && r_vld && !o_res.ready) |=> $stable(r_ch))
        else $error("tick advanced over a stalled beat");
    a_div_only_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_go |-> r_cmd.op == spsc_pkg::OP_CAL) else $error("divider started off calibrate");
    a_tick_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_res.kind) |-> !r_res.accepted) else $error("tick beat marked accepted");
`endif
endmodule

// ----- src/spsc_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsc_divider
// Restoring divider, one quotient bit per cycle: (num << 8) / den.
// ----------------------------------------------------------------------------
module spsc_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [8:0]  i_den,
    output logic        o_done,
    output logic [23:0] o_quot
);
    logic [23:0] r_quot;
    logic [9:0]  r_rem;
    logic [8:0]  r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [9:0]  w_sh;
    logic [10:0] w_diff;

    assign w_sh   = {r_rem[8:0], r_quot[23]};
    assign w_diff = {1'b0, w_sh} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == 5'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd24;
                r_quot <= {i_num, 8'd0};
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_diff[10]) begin
                    r_rem  <= w_diff[9:0];
                    r_quot <= {r_quot[22:0], 1'b1};
                end else begin
                    r_rem  <= w_sh;
                    r_quot <= {r_quot[22:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without work");
    a_cnt_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start) |-> r_cnt != 5'd0) else $error("divider count underflow");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
`endif
endmodule

// ----- sim/servo_pulse_slew_controller_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_pulse_slew_controller_tb
// Drives move, calibrate and tick commands into the servo controller, works
// out the expected pulse and status beats with a behavioural model of the
// channel table, and compares every result beat in order.
// ----------------------------------------------------------------------------
module servo_pulse_slew_controller_tb;

    localparam int WatchdogLimit = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = spsc_pkg::REG_ACTIVE;
    logic [15:0] i_cfg_data = '0;

    spsc_cmd_if cmd_ch ();
    spsc_res_if res_ch ();

    servo_pulse_slew_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_ch.sink),
        .o_res      (res_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Model state of the channel table.
    logic [4:0]  m_active;
    logic [15:0] m_center;
    logic [15:0] m_pos   [16];
    logic [15:0] m_tgt   [16];
    logic [9:0]  m_speed [16];
    logic [15:0] m_lo    [16];
    logic [15:0] m_hi    [16];
    logic [15:0] m_ppd   [16];
    logic [7:0]  m_trim  [16];

    spsc_pkg::t_res pending_beats[$];
    int   mismatches = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_cycles = 0;
    bit   timed_out = 1'b0;
    int   quiet_cycles = 0;

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        res_ch.ready = 1'b0;
    end

    function automatic int live_channels();
        return (m_active > 16) ? 16 : int'(m_active);
    endfunction

    function automatic logic [15:0] clamp_pulse(int ch, longint v);
        if (v < longint'(m_lo[ch])) return m_lo[ch];
        if (v > longint'(m_hi[ch])) return m_hi[ch];
        return v[15:0];
    endfunction

    function automatic void push_beat(logic k, int ch, logic [15:0] p, logic drv,
                                      logic acc, logic lst);
        spsc_pkg::t_res r;
        r.kind = k; r.channel_res = ch[3:0]; r.pulse = p;
        r.driven = drv; r.accepted = acc; r.last = lst;
        pending_beats.push_back(r);
    endfunction

    function automatic void predict_servo(spsc_pkg::t_cmd c);
        int     n;
        longint pos, tgt, spd, d, s, deg;
        longint unsigned mag, ppd;
        logic   ok;
        n = live_channels();
        ok = 1'b0;
        if (c.op == spsc_pkg::OP_TICK) begin
            for (int i = 0; i < n; i++) begin
                pos = longint'(m_pos[i]);
                tgt = longint'(m_tgt[i]);
                spd = longint'(m_speed[i]);
                if (pos == 0 || tgt == 0) begin
                    push_beat(1'b1, i, 16'd0, 1'b0, 1'b0, i + 1 == n);
                    continue;
                end
                if (pos > tgt) pos -= spd;
                else if (pos < tgt) pos += spd;
                else tgt = 0;
                d = pos - tgt;
                if (d < 0) d = -d;
                if (d < spd) pos = tgt;
                m_pos[i] = pos[15:0];
                m_tgt[i] = tgt[15:0];
                push_beat(1'b1, i, clamp_pulse(i, longint'(m_pos[i])), 1'b1, 1'b0, i + 1 == n);
            end
            return;
        end
        if (c.op == spsc_pkg::OP_MOVE) begin
            if (c.channel < n && c.angle <= 180) begin
                deg = longint'(c.angle) - 90 + longint'(m_trim[c.channel]);
                s = longint'(m_center) * 256 + deg * longint'(m_ppd[c.channel]);
                mag = (s < 0 ? -s : s) >> 8;
                if (mag > 65535) mag = 65535;
                m_tgt[c.channel] = clamp_pulse(c.channel, longint'(mag));
                m_speed[c.channel] = c.speed;
                ok = 1'b1;
            end
        end else if (c.op == spsc_pkg::OP_CAL) begin
            if (c.channel < n && c.span_degrees != 0 && c.pulse_min <= c.pulse_max) begin
                ppd = (longint'(c.pulse_max - c.pulse_min) << 8) / c.span_degrees;
                if (ppd > 65535) ppd = 65535;
                m_lo[c.channel] = c.pulse_min;
                m_hi[c.channel] = c.pulse_max;
                m_trim[c.channel] = c.trim_degrees;
                m_ppd[c.channel] = ppd[15:0];
                m_speed[c.channel] = spsc_pkg::CAL_SPEED;
                m_pos[c.channel] = m_center;
                m_tgt[c.channel] = m_center;
                ok = 1'b1;
            end
        end
        push_beat(1'b0, c.channel, 16'd0, 1'b0, ok, 1'b1);
    endfunction

    // Result beat checker and receiver back-pressure.
    always @(posedge i_clk) begin
        spsc_pkg::t_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", res_ch.data);
            end else begin
                want = pending_beats.pop_front();
                if (res_ch.data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p actual %p", want, res_ch.data);
                end
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles with no beat moving on either channel.
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("[servo_pulse_slew_controller] ERROR");
            $finish;
        end
    end

    // Valid stays up after an accept until the next command or an idle cycle
    // replaces it; the block is never ready in the cycle after an accept.
    task automatic send_cmd(spsc_pkg::t_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        predict_servo(c);
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == spsc_pkg::REG_ACTIVE) m_active = val[4:0];
        else m_center = val;
        @(posedge i_clk);
    endtask

    function automatic spsc_pkg::t_cmd make_cmd(logic [1:0] op, int ch);
        spsc_pkg::t_cmd c;
        c = '0;
        c.op = op; c.channel = ch[3:0];
        return c;
    endfunction

    function automatic spsc_pkg::t_cmd rand_cal(int ch);
        spsc_pkg::t_cmd c;
        c = make_cmd(spsc_pkg::OP_CAL, ch);
        c.pulse_min = 16'($urandom_range(500, 1400));
        c.pulse_max = 16'($urandom_range(1600, 2600));
        c.span_degrees = 9'($urandom_range(1, 360));
        c.trim_degrees = 8'($urandom_range(0, 20));
        c.angle = 8'($urandom); c.speed = 10'($urandom);
        return c;
    endfunction

    function automatic spsc_pkg::t_cmd rand_move(int ch);
        spsc_pkg::t_cmd c;
        c = make_cmd(spsc_pkg::OP_MOVE, ch);
        c.angle = 8'($urandom_range(0, 180));
        c.speed = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(1, 60));
        c.pulse_min = 16'($urandom); c.pulse_max = 16'($urandom);
        c.span_degrees = 9'($urandom); c.trim_degrees = 8'($urandom);
        return c;
    endfunction

    function automatic spsc_pkg::t_cmd rand_noise();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(spsc_pkg::t_cmd)-1:0];
    endfunction

    task automatic test_directed();
        spsc_pkg::t_cmd c;
        send_cmd(make_cmd(spsc_pkg::OP_TICK, 0));          // never calibrated: not driven
        c = make_cmd(spsc_pkg::OP_MOVE, 0); c.angle = 8'd90;
        send_cmd(c);
        c = make_cmd(spsc_pkg::OP_CAL, 0); c.span_degrees = 9'd0; c.pulse_max = 16'd2000;
        send_cmd(c);                                       // zero span is rejected
        c = make_cmd(spsc_pkg::OP_CAL, 0); c.span_degrees = 9'd180;
        c.pulse_min = 16'd2000; c.pulse_max = 16'd1000;
        send_cmd(c);                                       // min above max is rejected
        c = make_cmd(spsc_pkg::OP_CAL, 1); c.span_degrees = 9'd180; c.pulse_max = 16'd2000;
        send_cmd(c);                                       // inactive channel
        drain_results();
        write_reg(spsc_pkg::REG_ACTIVE, 16'd16);
        write_reg(spsc_pkg::REG_CENTER, 16'd1500);
        c = make_cmd(spsc_pkg::OP_CAL, 0); c.pulse_min = 16'd500; c.pulse_max = 16'd2500;
        c.span_degrees = 9'd180; c.trim_degrees = 8'd0;
        send_cmd(c);
        c = make_cmd(spsc_pkg::OP_CAL, 15); c.pulse_min = 16'd0; c.pulse_max = 16'hFFFF;
        c.span_degrees = 9'd1; c.trim_degrees = 8'd180;
        send_cmd(c);                                       // saturating factor
        c = make_cmd(spsc_pkg::OP_CAL, 7); c.pulse_min = 16'd1000; c.pulse_max = 16'd2000;
        c.span_degrees = 9'd360; c.trim_degrees = 8'hFF;
        send_cmd(c);
        c = make_cmd(spsc_pkg::OP_MOVE, 0); c.angle = 8'd180; c.speed = 10'h3FF; send_cmd(c);
        c = make_cmd(spsc_pkg::OP_MOVE, 15); c.angle = 8'd0; c.speed = 10'd0; send_cmd(c);
        c = make_cmd(spsc_pkg::OP_MOVE, 7); c.angle = 8'd181; send_cmd(c);   // bad angle
        c = make_cmd(spsc_pkg::OP_MOVE, 7); c.angle = 8'hFF; send_cmd(c);
        c = make_cmd(spsc_pkg::OP_MOVE, 7); c.angle = 8'd0; c.speed = 10'd7; send_cmd(c);
        send_cmd(make_cmd(spsc_pkg::OP_TICK, 0));
        send_cmd(make_cmd(spsc_pkg::OP_TICK, 0));
        c = make_cmd(spsc_pkg::OP_RSVD, 5); send_cmd(c);   // unknown op
        send_cmd(make_cmd(spsc_pkg::OP_TICK, 0));
        drain_results();
        write_reg(spsc_pkg::REG_ACTIVE, 16'd0);
        send_cmd(make_cmd(spsc_pkg::OP_TICK, 0));          // no channels: no beats
        c = make_cmd(spsc_pkg::OP_MOVE, 0); c.angle = 8'd45; send_cmd(c);
        drain_results();
        write_reg(spsc_pkg::REG_ACTIVE, 16'd31);           // above the channel count
        write_reg(spsc_pkg::REG_CENTER, 16'hFFFF);
        send_cmd(make_cmd(spsc_pkg::OP_TICK, 0));
        c = make_cmd(spsc_pkg::OP_MOVE, 3); c.angle = 8'd10; send_cmd(c);
        drain_results();
    endtask

    task automatic test_random(int count, int idle_s, int idle_r);
        int r, n;
        send_idle_pct = idle_s;
        recv_idle_pct = idle_r;
        n = live_channels();
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 15) send_cmd(rand_cal($urandom_range(n)));
            else if (r < 45) send_cmd(rand_move($urandom_range(n)));
            else if (r < 90) send_cmd(make_cmd(spsc_pkg::OP_TICK, $urandom));
            else send_cmd(rand_noise());
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        spsc_pkg::t_cmd c;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge i_clk);
        hold_cycles <= 300;
        for (int i = 0; i < 6; i++) begin
            c = (i % 2 == 0) ? make_cmd(spsc_pkg::OP_TICK, 0) : rand_move(i);
            send_cmd(c);
        end
        drain_results();   // the sender waits for every beat here
        send_cmd(make_cmd(spsc_pkg::OP_TICK, 0));
        drain_results();
    endtask

    initial begin
        for (int i = 0; i < 16; i++) begin
            m_pos[i] = '0; m_tgt[i] = '0; m_speed[i] = '0; m_lo[i] = '0;
            m_hi[i] = '0; m_ppd[i] = '0; m_trim[i] = '0;
        end
        m_active = spsc_pkg::ACTIVE_RESET;
        m_center = spsc_pkg::CENTER_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        write_reg(spsc_pkg::REG_ACTIVE, 16'd4);
        write_reg(spsc_pkg::REG_CENTER, 16'd1500);
        test_random(40, 35, 59);
        write_reg(spsc_pkg::REG_ACTIVE, 16'd16);
        write_reg(spsc_pkg::REG_CENTER, 16'd1200);
        test_random(40, 59, 35);
        write_reg(spsc_pkg::REG_ACTIVE, 16'd1);
        write_reg(spsc_pkg::REG_CENTER, 16'd0);
        test_random(10, 0, 0);
        write_reg(spsc_pkg::REG_ACTIVE, 16'd8);
        write_reg(spsc_pkg::REG_CENTER, 16'd1800);
        test_random(30, 0, 0);
        test_backpressure();
        if (mismatches == 0 && pending_beats.size() == 0)
            $display("[servo_pulse_slew_controller] OK");
        else
            $display("[servo_pulse_slew_controller] ERROR");
        $finish;
    end
endmodule
